[design/samm_pkg.sv]
// ----------------------------------------------------------------------------
// samm_pkg
// Shared types and constants for the stick arming and quad motor mixer.
// ----------------------------------------------------------------------------
package samm_pkg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [11:0] MOTOR_MAX = 12'd4095;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_THROTTLE_ARM_LEVEL = 3'd0,
        REG_STICK_LEFT_LEVEL   = 3'd1,
        REG_STICK_RIGHT_LEVEL  = 3'd2,
        REG_HOLD_TICKS         = 3'd3,
        REG_PLUS_HOLD_TICKS    = 3'd4,
        REG_MIN_MOTOR          = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic        [10:0] throttle;
        logic signed [11:0] roll_stick;
        logic signed [11:0] pitch_stick;
        logic signed [11:0] yaw_stick;
        logic        [15:0] timer_now;
    } in_item_t;

    typedef struct packed {
        logic [11:0] motor_front;
        logic [11:0] motor_left;
        logic [11:0] motor_right;
        logic [11:0] motor_rear;
        logic        is_armed;
        logic        x_layout;
        logic        gesture_done;
    } out_item_t;

    typedef struct packed {
        logic        [10:0] throttle_arm_level;
        logic signed [11:0] stick_left_level;
        logic signed [11:0] stick_right_level;
        logic        [15:0] hold_ticks;
        logic        [15:0] plus_hold_ticks;
        logic        [11:0] min_motor;
    } cfg_t;

    typedef struct packed {
        logic armed_now;
        logic x_mode_now;
        logic armed_next;
        logic x_mode_next;
        logic done;
    } gest_status_t;

endpackage

[design/samm_cfg.sv]
// ----------------------------------------------------------------------------
// samm_cfg
// APB register bank holding the thresholds, hold times and motor floor.
// ----------------------------------------------------------------------------
module samm_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [samm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [samm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [samm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output samm_pkg::cfg_t                      cfg
);
    import samm_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.throttle_arm_level <= 11'd100;
            cfg_reg.stick_left_level   <= -12'sd500;
            cfg_reg.stick_right_level  <= 12'sd500;
            cfg_reg.hold_ticks         <= 16'd1000;
            cfg_reg.plus_hold_ticks    <= 16'd16;
            cfg_reg.min_motor          <= 12'd10;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_THROTTLE_ARM_LEVEL: cfg_reg.throttle_arm_level <= pwdata[10:0];
                REG_STICK_LEFT_LEVEL:   cfg_reg.stick_left_level   <= pwdata[11:0];
                REG_STICK_RIGHT_LEVEL:  cfg_reg.stick_right_level  <= pwdata[11:0];
                REG_HOLD_TICKS:         cfg_reg.hold_ticks         <= pwdata[15:0];
                REG_PLUS_HOLD_TICKS:    cfg_reg.plus_hold_ticks    <= pwdata[15:0];
                REG_MIN_MOTOR:          cfg_reg.min_motor          <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_THROTTLE_ARM_LEVEL: prdata = {21'd0, cfg_reg.throttle_arm_level};
            REG_STICK_LEFT_LEVEL:   prdata = {20'd0, cfg_reg.stick_left_level};
            REG_STICK_RIGHT_LEVEL:  prdata = {20'd0, cfg_reg.stick_right_level};
            REG_HOLD_TICKS:         prdata = {16'd0, cfg_reg.hold_ticks};
            REG_PLUS_HOLD_TICKS:    prdata = {16'd0, cfg_reg.plus_hold_ticks};
            REG_MIN_MOTOR:          prdata = {20'd0, cfg_reg.min_motor};
            default:                prdata = '0;
        endcase
    end

endmodule

[design/samm_gesture.sv]
// ----------------------------------------------------------------------------
// samm_gesture
// Arming, disarming and layout gestures with the shared hold timer.
// ----------------------------------------------------------------------------
module samm_gesture (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  samm_pkg::in_item_t      item,
    input  samm_pkg::cfg_t          cfg,
    output samm_pkg::gest_status_t  status
);
    import samm_pkg::*;

    typedef struct packed {
        logic [15:0] start;
        logic        running;
        logic        fired;
    } hold_t;

    logic        armed_reg, armed_next;
    logic        x_mode_reg, x_mode_next;
    logic [15:0] hold_start_reg, hold_start_next;
    logic        hold_running_reg, hold_running_next;
    logic        done;

    logic signed [11:0] roll, yaw, left, right;
    logic               thr_down;

    // start the hold if idle, then test the elapsed ticks against the limit
    function automatic hold_t hold_check(logic [15:0] start, logic running,
                                         logic [15:0] now, logic [15:0] limit);
        hold_t       h;
        logic [15:0] elapsed;
        h.start   = running ? start : now;
        h.running = 1'b1;
        elapsed   = now - h.start;
        h.fired   = elapsed > limit;
        if (h.fired) begin
            h.running = 1'b0;
        end
        return h;
    endfunction

    assign roll     = item.roll_stick;
    assign yaw      = item.yaw_stick;
    assign left     = cfg.stick_left_level;
    assign right    = cfg.stick_right_level;
    assign thr_down = item.throttle < cfg.throttle_arm_level;

    always_comb begin
        hold_t h;
        logic  held;
        armed_next        = armed_reg;
        x_mode_next       = x_mode_reg;
        hold_start_next   = hold_start_reg;
        hold_running_next = hold_running_reg;
        held              = 1'b0;
        done              = 1'b0;
        h                 = '0;
        if (thr_down) begin
            // each gesture sees what the earlier ones left
            if (armed_next && yaw < left) begin
                h = hold_check(hold_start_next, hold_running_next,
                               item.timer_now, cfg.hold_ticks);
                held = 1'b1;
                hold_start_next   = h.start;
                hold_running_next = h.running;
                if (h.fired) begin
                    armed_next = 1'b0;
                    done       = 1'b1;
                end
            end
            if (!armed_next && yaw > right) begin
                h = hold_check(hold_start_next, hold_running_next,
                               item.timer_now, cfg.hold_ticks);
                held = 1'b1;
                hold_start_next   = h.start;
                hold_running_next = h.running;
                if (h.fired) begin
                    armed_next = 1'b1;
                    done       = 1'b1;
                end
            end
            if (!armed_next) begin
                if (roll > right) begin
                    h = hold_check(hold_start_next, hold_running_next,
                                   item.timer_now, cfg.hold_ticks);
                    held = 1'b1;
                    hold_start_next   = h.start;
                    hold_running_next = h.running;
                    if (h.fired) begin
                        x_mode_next = 1'b1;
                        done        = 1'b1;
                    end
                end else if (roll < left) begin
                    h = hold_check(hold_start_next, hold_running_next,
                                   item.timer_now, cfg.plus_hold_ticks);
                    held = 1'b1;
                    hold_start_next   = h.start;
                    hold_running_next = h.running;
                    if (h.fired) begin
                        x_mode_next = 1'b0;
                        done        = 1'b1;
                    end
                end
            end
        end
        // drop the hold when no gesture is held
        if (!held) begin
            hold_running_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg        <= 1'b0;
            x_mode_reg       <= 1'b0;
            hold_start_reg   <= '0;
            hold_running_reg <= 1'b0;
        end else if (advance) begin
            armed_reg        <= armed_next;
            x_mode_reg       <= x_mode_next;
            hold_start_reg   <= hold_start_next;
            hold_running_reg <= hold_running_next;
        end
    end

    assign status.armed_now   = armed_reg;
    assign status.x_mode_now  = x_mode_reg;
    assign status.armed_next  = armed_next;
    assign status.x_mode_next = x_mode_next;
    assign status.done        = done;

endmodule

[design/samm_mixer.sv]
// ----------------------------------------------------------------------------
// samm_mixer
// Plus or X motor mix with floor and high saturation; all motors zero unless armed with throttle up.
// ----------------------------------------------------------------------------
module samm_mixer (
    input  samm_pkg::in_item_t  item,
    input  samm_pkg::cfg_t      cfg,
    input  logic                armed,
    input  logic                x_mode,
    output logic [11:0]         motor_front,
    output logic [11:0]         motor_left,
    output logic [11:0]         motor_right,
    output logic [11:0]         motor_rear
);
    import samm_pkg::*;

    logic signed [14:0] thr, roll, pitch, yaw;
    logic signed [14:0] m1, m2, m3, m4;
    logic               fly;

    function automatic logic [11:0] clamp_motor(logic signed [14:0] v,
                                                logic [11:0] floor_val);
        logic [11:0] r;
        if (v < $signed({3'b000, floor_val})) begin
            r = floor_val;
        end else if (v > $signed({3'b000, MOTOR_MAX})) begin
            r = MOTOR_MAX;
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

    assign thr   = $signed({4'b0000, item.throttle});
    assign roll  = {{3{item.roll_stick[11]}}, item.roll_stick};
    assign pitch = {{3{item.pitch_stick[11]}}, item.pitch_stick};
    assign yaw   = {{3{item.yaw_stick[11]}}, item.yaw_stick};
    assign fly   = armed && !(item.throttle < cfg.throttle_arm_level);

    always_comb begin
        if (x_mode) begin
            m1 = thr + roll + pitch - yaw;
            m2 = thr + roll - pitch + yaw;
            m3 = thr - roll + pitch + yaw;
            m4 = thr - roll - pitch - yaw;
        end else begin
            m1 = thr + pitch - yaw;
            m2 = thr + roll + yaw;
            m3 = thr - roll + yaw;
            m4 = thr - pitch - yaw;
        end
    end

    assign motor_front = fly ? clamp_motor(m1, cfg.min_motor) : 12'd0;
    assign motor_left  = fly ? clamp_motor(m2, cfg.min_motor) : 12'd0;
    assign motor_right = fly ? clamp_motor(m3, cfg.min_motor) : 12'd0;
    assign motor_rear  = fly ? clamp_motor(m4, cfg.min_motor) : 12'd0;

endmodule

[design/stick_arming_and_quad_motor_mixer.sv]
// ----------------------------------------------------------------------------
// stick_arming_and_quad_motor_mixer
// Stick gesture arming, plus/X layout selection and four-motor mixing.
// ----------------------------------------------------------------------------
//  port group   direction  contents
//  s_*          in         receiver frame: sticks and tick counter
//  m_*          out        four motor commands and arming status
//  p*           in/out     APB register bank, 4-byte stride
//
//  One frame per cycle unless the result stalls. A frame is taken into the input
//  register, mixed and gated in a single pass, and lands in the result register
//  once that register is free; m_valid rises with it. The arming state moves
//  with each frame as it enters the result register. A stalled result holds
//  the input register full and no more; reset empties both stages and sets
//  disarmed, plus layout, no hold running.
// ----------------------------------------------------------------------------
module stick_arming_and_quad_motor_mixer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  samm_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output samm_pkg::out_item_t                 m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [samm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [samm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [samm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import samm_pkg::*;

    cfg_t         cfg;
    gest_status_t status;
    in_item_t     in_reg;
    logic         in_valid_reg;
    out_item_t    out_reg, out_next;
    logic         out_valid_reg;
    logic         advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    samm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    samm_gesture u_gesture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .status  (status)
    );

    samm_mixer u_mixer (
        .item        (in_reg),
        .cfg         (cfg),
        .armed       (status.armed_now),
        .x_mode      (status.x_mode_now),
        .motor_front (out_next.motor_front),
        .motor_left  (out_next.motor_left),
        .motor_right (out_next.motor_right),
        .motor_rear  (out_next.motor_rear)
    );

    assign out_next.is_armed     = status.armed_next;
    assign out_next.x_layout     = status.x_mode_next;
    assign out_next.gesture_done = status.done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[design/samm_checker.sv]
// ----------------------------------------------------------------------------
// samm_checker
// Port-level checks on the mixer outputs, bound to the top level.
// ----------------------------------------------------------------------------
module samm_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  samm_pkg::out_item_t                 m_data
);
    import samm_pkg::*;

    logic motors_zero;
    assign motors_zero = (m_data.motor_front == 12'd0) && (m_data.motor_left == 12'd0)
                      && (m_data.motor_right == 12'd0) && (m_data.motor_rear == 12'd0);

    // disarmed means every motor stopped
    a_disarmed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_armed |-> motors_zero)
        else $error("motor running while disarmed");

    // gestures complete only with throttle down, so motors are stopped
    a_gesture_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.gesture_done |-> motors_zero)
        else $error("motor running on a completed gesture");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind stick_arming_and_quad_motor_mixer samm_checker u_samm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
